FILE: design/fln_pkg.sv
// Shared types and constants of the force layout node step block.
// No dependencies; every other file of the block imports this package.
package fln_pkg;

	// Field and accumulator widths
	localparam int POS_W     = 24;
	localparam int ACC_W     = 48;
	localparam int ACC_FRAC  = 16;
	localparam int LINK_W    = 8;
	localparam int WGT_W     = 12;
	localparam int DEN_W     = 50;
	localparam int EXT_W     = 50;
	localparam int CFG_IDX_W = 2;

	// Force law constants
	localparam int REPULSE     = 75;
	localparam int WEIGHT_STEP = 10;
	localparam int MARGIN      = 10;
	localparam int STILL_LIMIT = 6554;
	localparam int MAX_LINKS   = 255;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECT_LEFT   = 2'd0,
		REG_RECT_RIGHT  = 2'd1,
		REG_RECT_TOP    = 2'd2,
		REG_RECT_BOTTOM = 2'd3
	} cfg_reg_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Stage loads of the placement unit
	typedef struct packed {
		logic load_tp;
		logic load_sum;
		logic load_out;
	} place_ctl_t;

endpackage

FILE: design/fln_if.sv
// Valid/ready channels of the force layout node step block: input items and results.
// Depends on fln_pkg for the field widths.
interface fln_item_if;
	import fln_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] self_x;
	logic signed [POS_W-1:0] self_y;
	logic signed [POS_W-1:0] other_x;
	logic signed [POS_W-1:0] other_y;
	logic                    other_linked;
	logic [LINK_W-1:0]       link_count;
	logic                    self_grabbed;
	logic                    last;

	modport source (
		output valid, self_x, self_y, other_x, other_y, other_linked, link_count,
		       self_grabbed, last,
		input  ready
	);
	modport sink (
		input  valid, self_x, self_y, other_x, other_y, other_linked, link_count,
		       self_grabbed, last,
		output ready
	);
endinterface

interface fln_result_if;
	import fln_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] new_x;
	logic signed [POS_W-1:0] new_y;
	logic                    moved;

	modport source (output valid, new_x, new_y, moved, input ready);
	modport sink (input valid, new_x, new_y, moved, output ready);
endinterface

FILE: design/fln_div.sv
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on fln_pkg; the caller guarantees the quotient fits in QUO_W bits.
module fln_div #(
	parameter int NUM_W = 56,
	parameter int QUO_W = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [fln_pkg::DEN_W-1:0]  den,
	output logic [QUO_W-1:0]           quo,
	output fln_pkg::div_stat_t         stat
);
	import fln_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// Trial subtract of the shifted partial remainder
	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[DEN_W];

	// Step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(QUO_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			sh_q  <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], fits};
		end
	end

	assign quo       = sh_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// A start always opens a run of steps
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");

	// The end of a run reports done
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("divider finished without done");

	// Restoring invariant: partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < den_q))
		else $error("divider remainder out of range");

endmodule

FILE: design/fln_place.sv
// One axis of the final placement: velocity to position, clamp, saturate, moved flag.
// Depends on fln_pkg; three stage loads come from the sequencer.
module fln_place #(
	parameter int POS_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  fln_pkg::place_ctl_t               ctl,
	input  logic signed [fln_pkg::POS_W-1:0]  self_pos,
	input  logic signed [fln_pkg::ACC_W-1:0]  vel,
	input  logic                              still,
	input  logic                              grabbed,
	input  logic signed [fln_pkg::POS_W-1:0]  lo_edge,
	input  logic signed [fln_pkg::POS_W-1:0]  hi_edge,
	output logic signed [fln_pkg::POS_W-1:0]  pos,
	output logic                              moved
);
	import fln_pkg::*;

	localparam int SHIFT = ACC_FRAC - POS_FRAC_BITS;
	localparam logic [ACC_W:0] BIAS = (ACC_W + 1)'((1 << SHIFT) - 1);
	localparam logic signed [EXT_W-1:0] MARGIN_E = EXT_W'(MARGIN * (1 << POS_FRAC_BITS));
	localparam logic signed [EXT_W-1:0] POS_MAX_E = EXT_W'((1 << (POS_W - 1)) - 1);
	localparam logic signed [EXT_W-1:0] POS_MIN_E = EXT_W'(-(1 << (POS_W - 1)));

	logic signed [ACC_W:0]   vsum;
	logic signed [ACC_W:0]   vshift;
	logic signed [EXT_W-1:0] tp_s1;
	logic signed [EXT_W-1:0] lo_s1;
	logic signed [EXT_W-1:0] hi_s1;
	logic signed [EXT_W-1:0] p_s2;
	logic signed [EXT_W-1:0] c_lo;
	logic signed [EXT_W-1:0] c_hi;
	logic signed [EXT_W-1:0] c_sat;
	logic signed [POS_W-1:0] res;
	logic signed [POS_W-1:0] pos_s3;
	logic                    moved_s3;

	// Shift toward zero: bias negative values before the arithmetic shift
	assign vsum   = {vel[ACC_W-1], vel} + (vel[ACC_W-1] ? BIAS : '0);
	assign vshift = vsum >>> SHIFT;

	// Stage 1: position step and inner edges
	always_ff @(posedge clk) begin
		if (ctl.load_tp) begin
			tp_s1 <= EXT_W'(vshift);
			lo_s1 <= EXT_W'(lo_edge) + MARGIN_E;
			hi_s1 <= EXT_W'(hi_edge) - MARGIN_E;
		end
	end

	// Stage 2: raw new position; drop the step when both axes are still
	always_ff @(posedge clk) begin
		if (ctl.load_sum) begin
			p_s2 <= EXT_W'(self_pos) + (still ? '0 : tp_s1);
		end
	end

	// Clamp inside the edges, upper edge wins, then saturate to the field
	always_comb begin
		c_lo  = (p_s2 < lo_s1) ? lo_s1 : p_s2;
		c_hi  = (c_lo > hi_s1) ? hi_s1 : c_lo;
		c_sat = c_hi;
		if (c_hi > POS_MAX_E) begin
			c_sat = POS_MAX_E;
		end else if (c_hi < POS_MIN_E) begin
			c_sat = POS_MIN_E;
		end
		res = grabbed ? self_pos : c_sat[POS_W-1:0];
	end

	// Stage 3: result payload, held until the next load
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			pos_s3   <= res;
			moved_s3 <= (res != self_pos);
		end
	end

	assign pos   = pos_s3;
	assign moved = moved_s3;

endmodule

FILE: design/force_layout_node_step_top.sv
// Each item runs 0, 2 or 4 divisions on the shared divider (two when the nodes differ, two
// more when linked); the quotient width is QUO_W = max(POS_FRAC_BITS+23, 37-POS_FRAC_BITS),
// 31 by default; a last item then passes the still check and the placement stages.
// One item at a time: a new item is taken only once the sequencer is back in idle.
// Reset (arst_n low): sequencer idle, velocity sums zero, no result, edges at +/-200.0.
// Top level of the force layout node step; depends on fln_pkg, fln_if, fln_div, fln_place.
module force_layout_node_step_top #(
	parameter int POS_FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fln_item_if.sink                            item,
	fln_result_if.source                        result,
	input  logic                                cfg_we,
	input  logic [fln_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [fln_pkg::POS_W-1:0]           cfg_data
);
	import fln_pkg::*;

	localparam int MAG_W      = POS_W + 1;
	localparam int MUL75_W    = MAG_W + 7;
	localparam int REP_SHIFT  = POS_FRAC_BITS + ACC_FRAC;
	localparam int ATT_SHIFT  = ACC_FRAC - POS_FRAC_BITS;
	localparam int REP_NUM_W  = MUL75_W + REP_SHIFT;
	localparam int ATT_NUM_W  = MAG_W + ATT_SHIFT;
	localparam int NUM_W      = (REP_NUM_W > ATT_NUM_W) ? REP_NUM_W : ATT_NUM_W;
	localparam int REP_QUO_W  = 7 + REP_SHIFT;
	localparam int ATT_QUO_W  = POS_W + ATT_SHIFT - 3;
	localparam int QUO_W      = (REP_QUO_W > ATT_QUO_W) ? REP_QUO_W : ATT_QUO_W;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] STILL_HI = ACC_W'(STILL_LIMIT);
	localparam logic signed [ACC_W-1:0] STILL_LO = -STILL_HI;
	localparam logic [POS_W-1:0] EDGE_LO_RST = POS_W'(-51200);
	localparam logic [POS_W-1:0] EDGE_HI_RST = POS_W'(51200);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_DIFF   = 11'b000_0000_0010,
		S_SQX    = 11'b000_0000_0100,
		S_SQY    = 11'b000_0000_1000,
		S_DEN    = 11'b000_0001_0000,
		S_DSTART = 11'b000_0010_0000,
		S_DWAIT  = 11'b000_0100_0000,
		S_ACC    = 11'b000_1000_0000,
		S_STILL  = 11'b001_0000_0000,
		S_PLACE1 = 11'b010_0000_0000,
		S_PLACE2 = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_REP_X = 2'd0,
		OP_REP_Y = 2'd1,
		OP_ATT_X = 2'd2,
		OP_ATT_Y = 2'd3
	} op_t;

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   op_load;

	logic [POS_W-1:0] rect_left_q, rect_right_q, rect_top_q, rect_bottom_q;

	logic signed [POS_W-1:0] sx_q, sy_q, ox_q, oy_q;
	logic                    linked_q, grabbed_q, last_q;
	logic [LINK_W-1:0]       links_q;

	logic [MAG_W-1:0]  ax_q, ay_q;
	logic              negx_q, negy_q;
	logic [WGT_W-1:0]  wgt_q;
	logic [DEN_W-1:0]  den_q, sq_q;
	logic signed [ACC_W-1:0] vel_x_q, vel_y_q;
	logic              still_q;
	logic              out_vld_q;

	logic signed [MAG_W-1:0] dx, dy;
	logic [LINK_W-1:0]       links_eff;
	logic [MAG_W-1:0]        mul_in;
	logic [2*MAG_W-1:0]      mul_p;
	logic [DEN_W-1:0]        den_sum;
	logic                    is_y, is_att;
	logic [MAG_W-1:0]        sel_mag;
	logic [MUL75_W-1:0]      mag75;
	logic [NUM_W-1:0]        div_num;
	logic [DEN_W-1:0]        div_den;
	logic [QUO_W-1:0]        div_quo;
	div_stat_t               div_stat;
	logic                    div_start;
	logic signed [ACC_W:0]   term;
	logic signed [ACC_W:0]   acc_sum;
	logic signed [ACC_W-1:0] acc_sel;
	logic signed [ACC_W-1:0] acc_new;
	logic                    in_fire;
	logic                    out_free;
	place_ctl_t              place_ctl;
	logic signed [POS_W-1:0] pos_x, pos_y;
	logic                    moved_x, moved_y;

	assign in_fire    = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign out_free   = !out_vld_q || result.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= EDGE_LO_RST;
			rect_right_q  <= EDGE_HI_RST;
			rect_top_q    <= EDGE_LO_RST;
			rect_bottom_q <= EDGE_HI_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_RECT_LEFT:   rect_left_q   <= cfg_data;
				REG_RECT_RIGHT:  rect_right_q  <= cfg_data;
				REG_RECT_TOP:    rect_top_q    <= cfg_data;
				REG_RECT_BOTTOM: rect_bottom_q <= cfg_data;
			endcase
		end
	end

	// Differences, magnitudes and attraction weight
	assign dx        = {sx_q[POS_W-1], sx_q} - {ox_q[POS_W-1], ox_q};
	assign dy        = {sy_q[POS_W-1], sy_q} - {oy_q[POS_W-1], oy_q};
	assign links_eff = (links_q > MAX_LINKS) ? LINK_W'(MAX_LINKS) : links_q;

	// Shared squarer, then the running sum of squares
	assign mul_in  = (state_q == S_SQX) ? ax_q : ay_q;
	assign mul_p   = mul_in * mul_in;
	assign den_sum = den_q + sq_q;

	// Operand selection for the shared divider
	assign is_y    = (op_q == OP_REP_Y) || (op_q == OP_ATT_Y);
	assign is_att  = (op_q == OP_ATT_X) || (op_q == OP_ATT_Y);
	assign sel_mag = is_y ? ay_q : ax_q;
	assign mag75   = MUL75_W'(sel_mag) * MUL75_W'(REPULSE);
	assign div_num = is_att ? (NUM_W'(sel_mag) << ATT_SHIFT) : (NUM_W'(mag75) << REP_SHIFT);
	assign div_den = is_att ? DEN_W'(wgt_q) : den_q;
	assign div_start = (state_q == S_DSTART);

	fln_div #(
		.NUM_W (NUM_W),
		.QUO_W (QUO_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// Signed, saturating accumulate of one quotient
	always_comb begin
		term    = (ACC_W + 1)'(div_quo);
		if ((is_y ? negy_q : negx_q) ^ is_att) begin
			term = -term;
		end
		acc_sel = is_y ? vel_y_q : vel_x_q;
		acc_sum = {acc_sel[ACC_W-1], acc_sel} + term;
		acc_new = acc_sum[ACC_W-1:0];
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_new = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		op_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_DIFF;
			end
			S_DIFF: state_d = S_SQX;
			S_SQX:  state_d = S_SQY;
			S_SQY:  state_d = S_DEN;
			S_DEN: begin
				if (den_sum != '0) begin
					op_d    = OP_REP_X;
					op_load = 1'b1;
					state_d = S_DSTART;
				end else if (linked_q) begin
					op_d    = OP_ATT_X;
					op_load = 1'b1;
					state_d = S_DSTART;
				end else begin
					state_d = last_q ? S_STILL : S_IDLE;
				end
			end
			S_DSTART: state_d = S_DWAIT;
			S_DWAIT: begin
				if (div_stat.done) state_d = S_ACC;
			end
			S_ACC: begin
				state_d = last_q ? S_STILL : S_IDLE;
				case (op_q)
					OP_REP_X: begin
						op_d    = OP_REP_Y;
						op_load = 1'b1;
						state_d = S_DSTART;
					end
					OP_REP_Y: begin
						if (linked_q) begin
							op_d    = OP_ATT_X;
							op_load = 1'b1;
							state_d = S_DSTART;
						end
					end
					OP_ATT_X: begin
						op_d    = OP_ATT_Y;
						op_load = 1'b1;
						state_d = S_DSTART;
					end
					default: ;
				endcase
			end
			S_STILL:  state_d = S_PLACE1;
			S_PLACE1: state_d = S_PLACE2;
			S_PLACE2: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Placement stage loads
	always_comb begin
		place_ctl.load_tp  = (state_q == S_STILL);
		place_ctl.load_sum = (state_q == S_PLACE1);
		place_ctl.load_out = (state_q == S_PLACE2) && out_free;
	end

	// Control state, velocity sums and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_REP_X;
			vel_x_q   <= '0;
			vel_y_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op_load) op_q <= op_d;
			if (state_q == S_ACC) begin
				if (is_y) vel_y_q <= acc_new;
				else      vel_x_q <= acc_new;
			end
			// Drop the sums once the placement has taken them
			if (state_q == S_PLACE1) begin
				vel_x_q <= '0;
				vel_y_q <= '0;
			end
			if (place_ctl.load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Captured transaction and per-item working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sx_q      <= item.self_x;
			sy_q      <= item.self_y;
			ox_q      <= item.other_x;
			oy_q      <= item.other_y;
			linked_q  <= item.other_linked;
			links_q   <= item.link_count;
			grabbed_q <= item.self_grabbed;
			last_q    <= item.last;
		end
		if (state_q == S_DIFF) begin
			ax_q   <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
			ay_q   <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
			negx_q <= dx[MAG_W-1];
			negy_q <= dy[MAG_W-1];
			wgt_q  <= (WGT_W'(links_eff) + WGT_W'(1)) * WGT_W'(WEIGHT_STEP);
		end
		if (state_q == S_SQX) den_q <= DEN_W'(mul_p);
		if (state_q == S_SQY) sq_q  <= DEN_W'(mul_p);
		if (state_q == S_DEN) den_q <= den_sum;
		if (state_q == S_STILL) begin
			still_q <= (vel_x_q > STILL_LO) && (vel_x_q < STILL_HI) &&
			           (vel_y_q > STILL_LO) && (vel_y_q < STILL_HI);
		end
	end

	// Both axes of the final placement
	fln_place #(
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_place_x (
		.clk      (clk),
		.ctl      (place_ctl),
		.self_pos (sx_q),
		.vel      (vel_x_q),
		.still    (still_q),
		.grabbed  (grabbed_q),
		.lo_edge  (rect_left_q),
		.hi_edge  (rect_right_q),
		.pos      (pos_x),
		.moved    (moved_x)
	);

	fln_place #(
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_place_y (
		.clk      (clk),
		.ctl      (place_ctl),
		.self_pos (sy_q),
		.vel      (vel_y_q),
		.still    (still_q),
		.grabbed  (grabbed_q),
		.lo_edge  (rect_top_q),
		.hi_edge  (rect_bottom_q),
		.pos      (pos_y),
		.moved    (moved_y)
	);

	assign result.valid = out_vld_q;
	assign result.new_x = pos_x;
	assign result.new_y = pos_y;
	assign result.moved = moved_x || moved_y;

	// An accepted transaction starts the difference step
	a_accept_diff: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_DIFF))
		else $error("accepted transaction did not start");

	// The divider only finishes while the sequencer waits on it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DWAIT))
		else $error("divider done outside the wait state");

	// A result appears only from the last placement stage
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_PLACE2))
		else $error("result raised outside placement");

	// Sums are cleared once a run has been placed
	a_sums_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == S_PLACE1) |-> (vel_x_q == '0 && vel_y_q == '0))
		else $error("velocity sums not cleared after placement");

endmodule

FILE: test/tb_force_layout_node_step_top.sv
`timescale 1ns / 100ps
// Testbench of force_layout_node_step_top: drives runs of node items, predicts each step result.
// Depends on fln_pkg, fln_if and the RTL of the block; needs no other file.
module tb_force_layout_node_step_top;
	import fln_pkg::*;

	localparam int     FRAC_BITS     = 8;
	localparam int     SETTLE_CYCLES = 160;
	localparam longint POS_MAX       = 64'sd8388607;
	localparam longint POS_MIN       = -64'sd8388608;
	localparam longint VEL_MAX       = 64'sh7FFF_FFFF_FFFF;
	localparam longint VEL_MIN       = -VEL_MAX - 1;
	localparam int     PRINT_CAP     = 100;

	typedef struct {
		logic signed [POS_W-1:0] self_x;
		logic signed [POS_W-1:0] self_y;
		logic signed [POS_W-1:0] other_x;
		logic signed [POS_W-1:0] other_y;
		logic                    linked;
		logic [LINK_W-1:0]       links;
		logic                    grabbed;
		logic                    is_last;
	} node_item_t;

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    moved;
	} node_pos_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [POS_W-1:0] cfg_data;

	fln_item_if   node_in ();
	fln_result_if node_out ();

	force_layout_node_step_top #(
		.POS_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (node_in),
		.result  (node_out),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	// Predicted scene bounds and velocity sums
	logic signed [POS_W-1:0] bound_left   = -24'sd51200;
	logic signed [POS_W-1:0] bound_right  = 24'sd51200;
	logic signed [POS_W-1:0] bound_top    = -24'sd51200;
	logic signed [POS_W-1:0] bound_bottom = 24'sd51200;
	longint vx_acc = 0;
	longint vy_acc = 0;

	node_pos_t expected_positions[$];
	int mismatch_count = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous limit on the whole run
	initial begin
		#60_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic longint mag64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint sat_vel(input longint v);
		if (v > VEL_MAX) return VEL_MAX;
		if (v < VEL_MIN) return VEL_MIN;
		return v;
	endfunction

	// Q16 velocity to position format, truncated toward zero
	function automatic longint vel_to_pos(input longint v);
		longint m;
		m = mag64(v) >> (ACC_FRAC - FRAC_BITS);
		return (v < 0) ? -m : m;
	endfunction

	// Add velocity, hold inside the margin (upper bound wins), saturate to the field
	function automatic logic signed [POS_W-1:0] place_axis(input longint self_p, input longint vel,
			input logic signed [POS_W-1:0] lo_reg, input logic signed [POS_W-1:0] hi_reg);
		longint margin;
		longint lo;
		longint hi;
		longint p;
		margin = longint'(MARGIN) * (longint'(1) << FRAC_BITS);
		lo = longint'(lo_reg) + margin;
		hi = longint'(hi_reg) - margin;
		p = self_p + vel_to_pos(vel);
		if (p < lo) p = lo;
		if (p > hi) p = hi;
		if (p > POS_MAX) p = POS_MAX;
		if (p < POS_MIN) p = POS_MIN;
		return p[POS_W-1:0];
	endfunction

	// Accumulate forces of one transaction; on the last one queue the new position
	task automatic predict_step(input node_item_t it);
		longint dx;
		longint dy;
		longint vx;
		longint vy;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] den;
		logic [63:0] qx;
		logic [63:0] qy;
		logic [63:0] w;
		int lk;
		node_pos_t res;
		dx = longint'(it.self_x) - longint'(it.other_x);
		dy = longint'(it.self_y) - longint'(it.other_y);
		ax = mag64(dx);
		ay = mag64(dy);
		den = ax * ax + ay * ay;
		if (den != 0) begin
			qx = (64'(REPULSE) * (ax << (FRAC_BITS + ACC_FRAC))) / den;
			qy = (64'(REPULSE) * (ay << (FRAC_BITS + ACC_FRAC))) / den;
			vx_acc = sat_vel(vx_acc + ((dx < 0) ? -longint'(qx) : longint'(qx)));
			vy_acc = sat_vel(vy_acc + ((dy < 0) ? -longint'(qy) : longint'(qy)));
		end
		if (it.linked) begin
			lk = (it.links > MAX_LINKS) ? MAX_LINKS : int'(it.links);
			w = 64'(lk + 1) * 64'(WEIGHT_STEP);
			qx = (ax << (ACC_FRAC - FRAC_BITS)) / w;
			qy = (ay << (ACC_FRAC - FRAC_BITS)) / w;
			vx_acc = sat_vel(vx_acc - ((dx < 0) ? -longint'(qx) : longint'(qx)));
			vy_acc = sat_vel(vy_acc - ((dy < 0) ? -longint'(qy) : longint'(qy)));
		end
		if (!it.is_last)
			return;

		if (it.grabbed) begin
			res.x = it.self_x;
			res.y = it.self_y;
		end else begin
			vx = vx_acc;
			vy = vy_acc;
			// Drop a velocity that is small on both axes
			if (mag64(vx) < STILL_LIMIT && mag64(vy) < STILL_LIMIT) begin
				vx = 0;
				vy = 0;
			end
			res.x = place_axis(longint'(it.self_x), vx, bound_left, bound_right);
			res.y = place_axis(longint'(it.self_y), vy, bound_top, bound_bottom);
		end
		res.moved = (res.x != it.self_x) || (res.y != it.self_y);
		vx_acc = 0;
		vy_acc = 0;
		expected_positions.push_back(res);
	endtask

	// Send one item transaction, after a random gap if tx_idle is set; valid stays high after the handshake
	task automatic send_item(input logic signed [POS_W-1:0] sx, input logic signed [POS_W-1:0] sy,
			input logic signed [POS_W-1:0] ox, input logic signed [POS_W-1:0] oy,
			input bit linked, input logic [LINK_W-1:0] links, input bit grabbed,
			input bit is_last);
		int gap;
		node_item_t it;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			node_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		node_in.valid        <= 1'b1;
		node_in.self_x       <= sx;
		node_in.self_y       <= sy;
		node_in.other_x      <= ox;
		node_in.other_y      <= oy;
		node_in.other_linked <= linked;
		node_in.link_count   <= links;
		node_in.self_grabbed <= grabbed;
		node_in.last         <= is_last;
		it = '{sx, sy, ox, oy, linked, links, grabbed, is_last};
		do @(posedge clk); while (node_in.ready !== 1'b1);
		predict_step(it);
	endtask

	// Drop valid, wait for every expected result, then let the block settle
	task automatic wait_idle();
		node_in.valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic signed [POS_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_RECT_LEFT:   bound_left = value;
			REG_RECT_RIGHT:  bound_right = value;
			REG_RECT_TOP:    bound_top = value;
			REG_RECT_BOTTOM: bound_bottom = value;
		endcase
	endtask

	task automatic set_bounds(input logic signed [POS_W-1:0] l, input logic signed [POS_W-1:0] r,
			input logic signed [POS_W-1:0] t, input logic signed [POS_W-1:0] b);
		wait_idle();
		write_reg(REG_RECT_LEFT, l);
		write_reg(REG_RECT_RIGHT, r);
		write_reg(REG_RECT_TOP, t);
		write_reg(REG_RECT_BOTTOM, b);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [POS_W-1:0] offset_pos(input logic signed [POS_W-1:0] p,
			input int r);
		longint v;
		v = longint'(p) + longint'($urandom_range(0, 2 * r)) - r;
		if (v > POS_MAX) v = POS_MAX;
		if (v < POS_MIN) v = POS_MIN;
		return v[POS_W-1:0];
	endfunction

	// One node's run of random other nodes; a few runs vary self, links and grab per item
	task automatic send_random_run(input int n);
		logic signed [POS_W-1:0] sx;
		logic signed [POS_W-1:0] sy;
		logic signed [POS_W-1:0] ox;
		logic signed [POS_W-1:0] oy;
		logic [LINK_W-1:0] links;
		bit grabbed;
		bit noisy;
		int kind;
		if ($urandom_range(0, 3) == 0) begin
			sx = POS_W'($urandom);
			sy = POS_W'($urandom);
		end else begin
			sx = POS_W'(int'($urandom_range(0, 153600)) - 76800);
			sy = POS_W'(int'($urandom_range(0, 153600)) - 76800);
		end
		links   = LINK_W'($urandom);
		grabbed = ($urandom_range(0, 7) == 0);
		noisy   = ($urandom_range(0, 9) == 0);
		tx_idle = ($urandom_range(0, 3) != 0);
		rx_idle = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n; i++) begin
			if (noisy) begin
				if ($urandom_range(0, 1)) sx = POS_W'($urandom);
				if ($urandom_range(0, 1)) sy = offset_pos(sy, 4000);
				links   = LINK_W'($urandom);
				grabbed = 1'($urandom_range(0, 1));
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					ox = sx;
					oy = sy;
				end
				1: begin
					ox = POS_W'($urandom);
					oy = POS_W'($urandom);
				end
				2: begin
					ox = offset_pos(sx, 8);
					oy = offset_pos(sy, 8);
				end
				default: begin
					ox = offset_pos(sx, ($urandom_range(0, 3) == 0) ? 4096 : 60000);
					oy = offset_pos(sy, ($urandom_range(0, 3) == 0) ? 4096 : 60000);
				end
			endcase
			send_item(sx, sy, ox, oy, 1'($urandom_range(0, 1)), links, grabbed, i == n - 1);
		end
	endtask

	task automatic send_random_items(input int total);
		int left;
		int len;
		left = total;
		while (left > 0) begin
			len = $urandom_range(1, 12);
			if (len > left) len = left;
			send_random_run(len);
			left -= len;
		end
	endtask

	// Hand-picked runs under the reset scene bounds
	task automatic test_directed_cases();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// coincident nodes: no repulsion, no pull
		send_item(0, 0, 0, 0, 1, 0, 0, 1);
		// one unit apart, lightest link weight
		send_item(256, 0, 0, 0, 1, 0, 0, 1);
		// one step apart: huge push into the right margin
		send_item(100, 100, 99, 100, 0, 8'd17, 0, 1);
		// field extremes, heaviest link weight
		send_item(24'sh7FFFFF, -24'sh800000, -24'sh800000, 24'sh7FFFFF, 1, 8'd255, 0, 1);
		// grabbed node at the extremes keeps its place
		send_item(24'sh7FFFFF, -24'sh800000, -24'sh800000, 24'sh7FFFFF, 1, 0, 1, 1);
		// far node: velocity below the still limit is dropped
		send_item(0, 0, 256000, 0, 0, 0, 0, 1);
		// just above the still limit on one axis
		send_item(0, 0, 180000, 0, 0, 0, 0, 1);
		// several others in one run, linked and not
		send_item(1280, -2560, 1000, -2000, 1, 8'd4, 0, 0);
		send_item(1280, -2560, -3000, 500, 0, 8'd4, 0, 0);
		send_item(1280, -2560, 1280, -2560, 1, 8'd4, 0, 0);
		send_item(1280, -2560, 1290, -2570, 1, 8'd4, 0, 1);
		// grabbed outside the scene with a big push
		send_item(76800, 0, 76801, 0, 1, 8'd1, 1, 1);
		// outside the scene at rest: pulled back inside
		send_item(76800, -76800, 76800, -76800, 0, 0, 0, 1);
		// negative direction with a linked neighbor
		send_item(-512, -512, -256, -256, 1, 8'd3, 0, 1);
		// self moves within a run
		send_item(5000, 5000, 4000, 4000, 1, 8'd9, 0, 0);
		send_item(-5000, 6000, -4000, 6500, 1, 8'd200, 0, 1);
	endtask

	// Extreme scene bounds: full field, narrower than the margins, inverted
	task automatic test_bound_extremes();
		set_bounds(-24'sh800000, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
		send_random_items(150);
		set_bounds(0, 2560, -1000, -1000);
		send_random_items(150);
		set_bounds(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
		send_random_items(100);
	endtask

	task automatic test_random_layout();
		set_bounds(-20000, 90000, -60000, 30000);
		send_random_items(700);
		set_bounds(-51200, 51200, -51200, 51200);
		send_random_items(800);
	endtask

	// Accept results with random stalls, before or after valid shows up
	initial begin : result_sink
		int stall;
		node_out.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				node_out.ready <= 1'b0;
				if ($urandom_range(0, 1))
					do @(posedge clk); while (node_out.valid !== 1'b1);
				repeat (stall) @(posedge clk);
			end
			node_out.ready <= 1'b1;
			do @(posedge clk); while (node_out.valid !== 1'b1);
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		node_pos_t want;
		if (node_out.valid === 1'b1 && node_out.ready === 1'b1) begin
			if (expected_positions.size() == 0) begin
				report_mismatch("result with none expected, new_x", node_out.new_x, 0);
			end else begin
				want = expected_positions.pop_front();
				if (node_out.new_x !== want.x)
					report_mismatch("new_x", node_out.new_x, want.x);
				if (node_out.new_y !== want.y)
					report_mismatch("new_y", node_out.new_y, want.y);
				if (node_out.moved !== want.moved)
					report_mismatch("moved", node_out.moved, want.moved);
			end
		end
	end

	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_idx              <= REG_RECT_LEFT;
		cfg_data             <= '0;
		node_in.valid        <= 1'b0;
		node_in.self_x       <= '0;
		node_in.self_y       <= '0;
		node_in.other_x      <= '0;
		node_in.other_y      <= '0;
		node_in.other_linked <= 1'b0;
		node_in.link_count   <= '0;
		node_in.self_grabbed <= 1'b0;
		node_in.last         <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_bound_extremes();
		test_random_layout();

		wait_idle();
		if (expected_positions.size() != 0)
			report_mismatch("results never arrived", 0, expected_positions.size());
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
